>>> sv/tpr_pkg.sv
// ----------------------------------------------------------------------------
// tpr_pkg
// Types, constants and lookup functions shared by the teletext row decoder.
// ----------------------------------------------------------------------------
package tpr_pkg;

	localparam int unsigned PACKET_BYTES_DEF = 42;
	localparam int unsigned DISPLAY_ROWS_DEF = 26;

	// result kinds
	localparam logic KIND_GLYPH  = 1'b0;
	localparam logic KIND_HEADER = 1'b1;

	// byte positions inside a packet
	localparam int unsigned POS_ADDR_LO   = 0;
	localparam int unsigned POS_ADDR_HI   = 1;
	localparam int unsigned POS_PAGE_LO   = 2;
	localparam int unsigned POS_PAGE_HI   = 3;
	localparam int unsigned POS_SUB_0     = 4;
	localparam int unsigned POS_SUB_1     = 5;
	localparam int unsigned POS_SUB_2     = 6;
	localparam int unsigned POS_SUB_3     = 7;
	localparam int unsigned POS_CONTROL   = 9;
	localparam int unsigned POS_HDR_TEXT  = 10;
	localparam int unsigned POS_ROW_TEXT  = 2;

	// control characters
	localparam logic [6:0] CTRL_LIMIT    = 7'h20;
	localparam logic [6:0] CTRL_BLACK_BG = 7'h1C;
	localparam logic [6:0] CTRL_NEW_BG   = 7'h1D;

	localparam logic [2:0] COLOUR_WHITE = 3'd7;
	localparam logic [2:0] COLOUR_BLACK = 3'd0;
	localparam logic [2:0] LANG_LIMIT   = 3'd6;

	localparam logic [15:0] SUBCODE_MASK = 16'h3F7F;
	localparam logic [3:0]  MAG_ZERO_AS  = 4'h8;
	localparam logic [3:0]  NATIONAL_BASE = 4'hA;

	localparam logic [4:0] NAT_MISS = 5'h10;

	typedef struct packed {
		logic [3:0]  addr_lo;
		logic [2:0]  mag;
		logic [4:0]  row;
		logic [7:0]  page;
		logic [15:0] sub;
		logic [2:0]  lang;
		logic [2:0]  fg;
		logic [2:0]  bg;
		logic        mosaic;
	} tpr_state_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  row_number;
		logic [7:0]  glyph;
		logic [2:0]  fg_colour;
		logic [2:0]  bg_colour;
		logic [11:0] page_number;
		logic [13:0] subpage;
		logic        last_in_line;
	} tpr_result_t;

	localparam tpr_state_t STATE_RESET = '{
		addr_lo: 4'd0, mag: 3'd0, row: 5'd0, page: 8'd0, sub: 16'd0,
		lang: 3'd0, fg: COLOUR_WHITE, bg: COLOUR_BLACK, mosaic: 1'b0
	};

	// hamming data bits 1,3,5,7, no correction
	function automatic logic [3:0] data_nibble(input logic [7:0] b);
		return {b[7], b[5], b[3], b[1]};
	endfunction

	// national option slot, bit 4 set when the character has none
	function automatic logic [4:0] nat_slot(input logic [6:0] c);
		logic [4:0] s;
		case (c)
			7'h23: s = 5'd0;
			7'h24: s = 5'd1;
			7'h40: s = 5'd2;
			7'h5B: s = 5'd3;
			7'h5C: s = 5'd4;
			7'h5D: s = 5'd5;
			7'h5E: s = 5'd6;
			7'h5F: s = 5'd7;
			7'h60: s = 5'd8;
			7'h7B: s = 5'd9;
			7'h7C: s = 5'd10;
			7'h7D: s = 5'd11;
			7'h7E: s = 5'd12;
			default: s = NAT_MISS;
		endcase
		return s;
	endfunction

endpackage

>>> sv/tpr_decode.sv
// ----------------------------------------------------------------------------
// tpr_decode
// Single-pass decode of one packet byte: next state and optional result.
// ----------------------------------------------------------------------------
module tpr_decode
	import tpr_pkg::*;
#(
	parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int unsigned DISPLAY_ROWS = DISPLAY_ROWS_DEF,
	localparam int unsigned POS_W = $clog2(PACKET_BYTES)
) (
	input  logic [7:0]       data_byte,
	input  logic [POS_W-1:0] pos,
	input  tpr_state_t       st,
	output logic [POS_W-1:0] pos_next,
	output tpr_state_t       st_next,
	output logic             res_valid,
	output tpr_result_t      res
);

	logic [3:0]       nib;
	logic [6:0]       c;
	logic [4:0]       slot;
	logic [7:0]       c_ext;
	logic [7:0]       glyph;
	logic [POS_W-1:0] start;
	logic             row_shown;

	assign nib       = data_nibble(data_byte);
	assign c         = data_byte[6:0];
	assign c_ext     = {1'b0, c};
	assign slot      = nat_slot(c);
	assign row_shown = {1'b0, st.row} < 6'(DISPLAY_ROWS);
	assign start     = (st.row == 5'd0) ? POS_W'(POS_HDR_TEXT) : POS_W'(POS_ROW_TEXT);
	assign pos_next  = (pos == POS_W'(PACKET_BYTES - 1)) ? '0 : pos + 1'b1;

	always_comb begin
		st_next   = st;
		res_valid = 1'b0;
		res       = '0;
		glyph     = 8'd0;
		if (pos == POS_W'(POS_ADDR_LO)) begin
			st_next.addr_lo = nib;
		end else if (pos == POS_W'(POS_ADDR_HI)) begin
			st_next.mag    = st.addr_lo[2:0];
			st_next.row    = {nib, st.addr_lo[3]};
			st_next.fg     = COLOUR_WHITE;
			st_next.bg     = COLOUR_BLACK;
			st_next.mosaic = 1'b0;
		end else begin
			if (st.row == 5'd0) begin
				if (pos == POS_W'(POS_PAGE_LO)) begin
					st_next.page = {4'd0, nib};
				end else if (pos == POS_W'(POS_PAGE_HI)) begin
					st_next.page = {nib, st.page[3:0]};
				end else if (pos == POS_W'(POS_SUB_0)) begin
					st_next.sub = {12'd0, nib};
				end else if (pos == POS_W'(POS_SUB_1)) begin
					st_next.sub[7:4] = nib;
				end else if (pos == POS_W'(POS_SUB_2)) begin
					st_next.sub[11:8] = nib;
				end else if (pos == POS_W'(POS_SUB_3)) begin
					st_next.sub[15:12] = nib;
				end else if (pos == POS_W'(POS_CONTROL)) begin
					st_next.lang    = nib[2:0];
					res_valid       = 1'b1;
					res.kind        = KIND_HEADER;
					res.page_number = {(st.mag == 3'd0) ? MAG_ZERO_AS : {1'b0, st.mag},
						st.page};
					res.subpage     = 14'(st.sub & SUBCODE_MASK);
				end
			end
			if (pos >= start && row_shown) begin
				if (c < CTRL_LIMIT) begin
					if (!c[3]) begin
						st_next.fg     = c[2:0];
						st_next.mosaic = c[4];
					end
					if (c == CTRL_BLACK_BG) begin
						st_next.bg = COLOUR_BLACK;
					end else if (c == CTRL_NEW_BG) begin
						st_next.bg = st.fg;
					end
				end else if (!st.mosaic) begin
					if (slot[4]) begin
						glyph = c_ext - 8'h20;
					end else if (st.lang >= LANG_LIMIT) begin
						glyph = 8'd0;
					end else begin
						glyph = {NATIONAL_BASE + {1'b0, st.lang}, slot[3:0]};
					end
				end else if (c <= 7'h3F) begin
					glyph = c_ext + 8'h40;
				end else if (c <= 7'h5F) begin
					glyph = c_ext - 8'h20;
				end else begin
					glyph = c_ext + 8'h20;
				end
				res_valid        = 1'b1;
				res              = '0;
				res.kind         = KIND_GLYPH;
				res.row_number   = st.row;
				res.glyph        = glyph;
				res.fg_colour    = st_next.fg;
				res.bg_colour    = st_next.bg;
				res.last_in_line = (pos == POS_W'(PACKET_BYTES - 1));
			end
		end
	end

endmodule

>>> sv/teletext_packet_row_decoder.sv
// ----------------------------------------------------------------------------
// teletext_packet_row_decoder
// Cuts a byte stream into teletext packets and emits header and glyph records.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle with no gaps needed while the skid stage
// is empty; its record, if any, goes to the output register, or to the skid
// stage while the output register is held. Each byte gives at most one record,
// decoded in a single pass between the packet state registers and the output
// register. A one-entry skid stage behind it lets one more record in while a
// record is held by the sink. Framing is by byte count alone, starting at reset.
module teletext_packet_row_decoder
	import tpr_pkg::*;
#(
	parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int unsigned DISPLAY_ROWS = DISPLAY_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // row_number, glyph, fg_colour, bg_colour,
	                               // page_number, subpage, zero fill
	output logic        m_tuser,   // kind
	output logic        m_tlast    // last_in_line
);

	localparam int unsigned POS_W = $clog2(PACKET_BYTES);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_next;
	tpr_state_t       st_q;
	tpr_state_t       st_next;
	logic             res_valid;
	tpr_result_t      res;

	tpr_result_t      out_q;
	logic             out_valid_q;
	tpr_result_t      skid_q;
	logic             skid_valid_q;

	logic             acc;
	logic             push;
	logic             out_free;

	tpr_decode #(
		.PACKET_BYTES(PACKET_BYTES),
		.DISPLAY_ROWS(DISPLAY_ROWS)
	) u_decode (
		.data_byte(s_tdata),
		.pos      (pos_q),
		.st       (st_q),
		.pos_next (pos_next),
		.st_next  (st_next),
		.res_valid(res_valid),
		.res      (res)
	);

	assign s_tready = !skid_valid_q;
	assign acc      = s_tvalid && s_tready;
	assign push     = acc && res_valid;
	assign out_free = !out_valid_q || m_tready;

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			st_q  <= STATE_RESET;
		end else if (acc) begin
			pos_q <= pos_next;
			st_q  <= st_next;
		end
	end

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last_in_line;
	assign m_tdata  = {3'd0, out_q.subpage, out_q.page_number, out_q.bg_colour,
		out_q.fg_colour, out_q.glyph, out_q.row_number};

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(PACKET_BYTES - 1))
		else $error("byte position beyond packet length");

	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pos_q == POS_W'(PACKET_BYTES - 1)) |=> (pos_q == '0))
		else $error("byte position did not wrap at packet end");

	a_header_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.kind == KIND_HEADER) |-> (st_q.row == 5'd0))
		else $error("header record outside row 0");

	a_stall_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready && skid_valid_q) |=> $stable(skid_q))
		else $error("held skid transaction overwritten");

endmodule
